[rtl/core/rtps_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_pkg: shared types and constants for the prescaler search
// Constants of the 13.56 MHz timer setup and the controller/datapath link.
// ----------------------------------------------------------------------------
package rtps_pkg;

	localparam int DELAY_W = 16;
	localparam int NUM_W   = 32;
	localparam int PRESC_W = 12;
	localparam int RELOAD_W = 16;
	localparam int DIVR_W  = 16;
	localparam int CNT_W   = 5;

	// reader clock in kHz: 14 bits are enough for 13560
	localparam int CLK_KHZ_W = 14;
	localparam logic [CLK_KHZ_W-1:0] CLK_KHZ      = 14'd13560;
	localparam logic [PRESC_W-1:0]   PRESC_LIMIT  = 12'hFFF;
	localparam logic [RELOAD_W-1:0]  RELOAD_LIMIT = 16'hFFFF;
	// divisor of the last try, at prescaler PRESC_LIMIT - 1
	localparam logic [DIVR_W-1:0]    FALLBACK_DIVR =
		{3'b000, PRESC_LIMIT - 12'd1, 1'b1};
	localparam logic [CNT_W-1:0]     DIV_LAST = CNT_W'(NUM_W - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START1,
		ST_DIV1,
		ST_START2,
		ST_DIV2,
		ST_DONE
	} rtps_state_t;

	typedef struct packed {
		logic load_num;
		logic div_start;
		logic div_second;
		logic div_step;
		logic load_out;
	} rtps_cmd_t;

	typedef struct packed {
		logic div_last;
	} rtps_status_t;

endpackage

[rtl/core/rtps_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_datapath: numerator, shared restoring divider and result registers
// First divide gives N / 0xFFFF, which fixes the prescaler; second divide
// gives the reload value N / (2p + 1).
// ----------------------------------------------------------------------------
module rtps_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  rtps_pkg::rtps_cmd_t             cmd,
	output rtps_pkg::rtps_status_t          status,
	input  logic [rtps_pkg::DELAY_W-1:0]    delay_ms,
	output logic [rtps_pkg::PRESC_W-1:0]    prescaler,
	output logic [rtps_pkg::RELOAD_W-1:0]   reload,
	output logic                            out_of_range
);

	localparam int PROD_W = rtps_pkg::DELAY_W + rtps_pkg::CLK_KHZ_W;

	logic [rtps_pkg::NUM_W-1:0]    num_q;
	logic [rtps_pkg::NUM_W-1:0]    quo_q;
	logic [rtps_pkg::DIVR_W-1:0]   rem_q;
	logic [rtps_pkg::DIVR_W-1:0]   divr_q;
	logic [rtps_pkg::CNT_W-1:0]    cnt_q;
	logic [rtps_pkg::PRESC_W-1:0]  presc_q;
	logic                          oor_q;

	logic [PROD_W-1:0]             prod;
	logic [rtps_pkg::DIVR_W:0]     trial;
	logic                          trial_ge;
	logic [17:0]                   q_inc;
	logic [16:0]                   p_full;
	logic                          fits;
	logic [rtps_pkg::DIVR_W-1:0]   divr_next;

	assign prod = PROD_W'(delay_ms) * PROD_W'(rtps_pkg::CLK_KHZ);

	assign trial    = {rem_q, quo_q[rtps_pkg::NUM_W-1]};
	assign trial_ge = trial >= {1'b0, divr_q};

	// smallest p with 2p + 1 > N / 0xFFFF
	assign q_inc  = {1'b0, quo_q[16:0]} + 18'd1;
	assign p_full = q_inc[17:1];
	assign fits   = p_full < {5'd0, rtps_pkg::PRESC_LIMIT};
	assign divr_next = fits ? {p_full[14:0], 1'b1} : rtps_pkg::FALLBACK_DIVR;

	assign status.div_last = cnt_q == rtps_pkg::DIV_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_num) begin
			num_q <= rtps_pkg::NUM_W'(prod) - 32'd1;
		end
		if (cmd.div_start) begin
			rem_q <= '0;
			quo_q <= num_q;
			if (cmd.div_second) begin
				divr_q  <= divr_next;
				presc_q <= fits ? p_full[rtps_pkg::PRESC_W-1:0] : rtps_pkg::PRESC_LIMIT;
				oor_q   <= !fits;
			end else begin
				divr_q <= rtps_pkg::RELOAD_LIMIT;
			end
		end else if (cmd.div_step) begin
			// restoring step: shift in the next numerator bit
			if (trial_ge) begin
				rem_q <= rtps_pkg::DIVR_W'(trial - {1'b0, divr_q});
			end else begin
				rem_q <= trial[rtps_pkg::DIVR_W-1:0];
			end
			quo_q <= {quo_q[rtps_pkg::NUM_W-2:0], trial_ge};
		end
		if (cmd.load_out) begin
			prescaler    <= presc_q;
			reload       <= quo_q[rtps_pkg::RELOAD_W-1:0];
			out_of_range <= oor_q;
		end
	end

endmodule

[rtl/core/rtps_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtps_ctrl: sequencer for the prescaler search
// Runs two 32-step divisions per request and hands off the result.
// ----------------------------------------------------------------------------
module rtps_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  logic                    out_stall,
	output rtps_pkg::rtps_cmd_t     cmd,
	input  rtps_pkg::rtps_status_t  status
);

	rtps_pkg::rtps_state_t state_q;
	rtps_pkg::rtps_state_t state_next;
	logic                  out_valid_q;
	logic                  out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != rtps_pkg::ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		state_next = state_q;
		unique case (state_q)
			rtps_pkg::ST_IDLE: begin
				if (in_valid) state_next = rtps_pkg::ST_START1;
			end
			rtps_pkg::ST_START1: state_next = rtps_pkg::ST_DIV1;
			rtps_pkg::ST_DIV1: begin
				if (status.div_last) state_next = rtps_pkg::ST_START2;
			end
			rtps_pkg::ST_START2: state_next = rtps_pkg::ST_DIV2;
			rtps_pkg::ST_DIV2: begin
				if (status.div_last) state_next = rtps_pkg::ST_DONE;
			end
			rtps_pkg::ST_DONE: begin
				if (out_free) state_next = rtps_pkg::ST_IDLE;
			end
			default: state_next = rtps_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			rtps_pkg::ST_IDLE:   cmd.load_num = in_valid;
			rtps_pkg::ST_START1: cmd.div_start = 1'b1;
			rtps_pkg::ST_DIV1:   cmd.div_step = 1'b1;
			rtps_pkg::ST_START2: begin
				cmd.div_start  = 1'b1;
				cmd.div_second = 1'b1;
			end
			rtps_pkg::ST_DIV2:   cmd.div_step = 1'b1;
			rtps_pkg::ST_DONE:   cmd.load_out = out_free;
			default:             cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= rtps_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_next;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[rtl/core/rf_timer_prescaler_search.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_timer_prescaler_search: timer prescaler and reload for a 13.56 MHz clock
// Turns a timeout in milliseconds into the first fitting prescaler and reload.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall carries delay_ms; output channel
//   out_valid/out_stall carries prescaler, reload and out_of_range.
//   Each request gives exactly one result.
//   The shared radix-2 divider runs 32 steps for N / 0xFFFF and then
//   32 steps for N / (2p + 1).
//   A new request is taken only once the last one is in the output register;
//   in_stall is high while a request is in work.
//   The next request is taken while a finished result still waits in the
//   output register; if that result is still stalled when the next one is
//   done, the block holds the new one until the receiver takes the old.
//   Reset clears the sequencer and the output valid; no clearing pass.
// ----------------------------------------------------------------------------
module rf_timer_prescaler_search (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [rtps_pkg::DELAY_W-1:0]   delay_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [rtps_pkg::PRESC_W-1:0]   prescaler,
	output logic [rtps_pkg::RELOAD_W-1:0]  reload,
	output logic                           out_of_range
);

	rtps_pkg::rtps_cmd_t    cmd;
	rtps_pkg::rtps_status_t status;

	rtps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd),
		.status    (status)
	);

	rtps_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.delay_ms     (delay_ms),
		.prescaler    (prescaler),
		.reload       (reload),
		.out_of_range (out_of_range)
	);

endmodule

[dv/rf_timer_prescaler_search_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf_timer_prescaler_search_test: self-checking bench for the prescaler search
// Sends timeout requests with bursty valid and random output stalls. Each
// result is compared with a prescaler search computed in the bench.
// ----------------------------------------------------------------------------
module rf_timer_prescaler_search_test;

	import rtps_pkg::*;

	localparam int RANDOM_REQUESTS = 1500;
	localparam int CYCLE_LIMIT     = 2_000_000;
	localparam int DRAIN_CYCLES    = 80;

	typedef struct {
		logic [PRESC_W-1:0]  prescaler;
		logic [RELOAD_W-1:0] reload;
		logic                out_of_range;
	} timer_setting_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [DELAY_W-1:0]   delay_ms = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [PRESC_W-1:0]   prescaler;
	logic [RELOAD_W-1:0]  reload;
	logic                 out_of_range;

	timer_setting_t pending_settings[$];
	int unsigned    error_count = 0;
	int unsigned    requests_sent = 0;
	int unsigned    overrange_sent = 0;
	int unsigned    results_checked = 0;
	int unsigned    cycle_count = 0;
	int unsigned    burst_left = 1;
	int unsigned    stall_mode = 0;
	int unsigned    stall_phase_left = 0;
	int unsigned    stall_run_left = 0;
	logic           stall_level = 1'b0;

	rf_timer_prescaler_search dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.delay_ms     (delay_ms),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.prescaler    (prescaler),
		.reload       (reload),
		.out_of_range (out_of_range)
	);

	always #6 clk = ~clk;

	// First prescaler whose quotient drops below the reload limit
	function automatic timer_setting_t search_timer_setting(logic [DELAY_W-1:0] d);
		timer_setting_t s;
		logic [NUM_W-1:0] num;
		logic [NUM_W-1:0] quot;
		logic [NUM_W-1:0] p;
		bit found;
		num = NUM_W'(d) * NUM_W'(CLK_KHZ) - NUM_W'(1);
		quot = '0;
		p = '0;
		found = 1'b0;
		while (p < NUM_W'(PRESC_LIMIT) && !found) begin
			quot = num / (p * 2 + 1);
			if (quot < NUM_W'(RELOAD_LIMIT))
				found = 1'b1;
			else
				p = p + 1;
		end
		s.prescaler = p[PRESC_W-1:0];
		s.reload = quot[RELOAD_W-1:0];
		s.out_of_range = !found;
		return s;
	endfunction

	// Offer one request, hold it until taken, then maybe pause
	task automatic send_request(input logic [DELAY_W-1:0] d);
		timer_setting_t s;
		in_valid <= 1'b1;
		delay_ms <= d;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		s = search_timer_setting(d);
		pending_settings.push_back(s);
		requests_sent++;
		if (s.out_of_range)
			overrange_sent++;
		burst_left--;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 20)) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 30)
				: $urandom_range(1, 6);
		end
	endtask

	task automatic test_field_extremes();
		send_request(16'h0000);
		send_request(16'h0001);
		send_request(16'hFFFF);
		send_request(16'hFFFE);
		send_request(16'h5555);
		send_request(16'hAAAA);
		send_request(16'h8000);
		send_request(16'h7FFF);
	endtask

	// Delays on either side of the first two prescaler steps
	task automatic test_prescaler_steps();
		send_request(16'd4);
		send_request(16'd5);
		send_request(16'd14);
		send_request(16'd15);
	endtask

	// Bisect for the largest delay that still fits below the prescaler limit
	task automatic test_range_edge();
		int unsigned lo;
		int unsigned hi;
		int unsigned mid;
		timer_setting_t s;
		lo = 1;
		hi = 65535;
		while (hi - lo > 1) begin
			mid = (lo + hi) / 2;
			s = search_timer_setting(DELAY_W'(mid));
			if (s.out_of_range)
				hi = mid;
			else
				lo = mid;
		end
		send_request(DELAY_W'(lo - 1));
		send_request(DELAY_W'(lo));
		send_request(DELAY_W'(hi));
		send_request(DELAY_W'(hi + 1));
	endtask

	task automatic test_random_delays();
		int unsigned pick;
		logic [DELAY_W-1:0] d;
		for (int i = 0; i < RANDOM_REQUESTS; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3)
				d = DELAY_W'($urandom_range(0, 40));
			else if (pick < 5)
				d = DELAY_W'($urandom_range(39000, 40500));
			else
				d = DELAY_W'($urandom_range(0, 65535));
			send_request(d);
		end
	endtask

	// Check each taken result, then pick the stall for the next cycle
	always @(posedge clk) begin
		timer_setting_t exp_s;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_settings.size() == 0) begin
				$error("result with no request pending: prescaler %0d reload %0d",
					prescaler, reload);
				error_count++;
			end else begin
				exp_s = pending_settings.pop_front();
				results_checked++;
				if (prescaler !== exp_s.prescaler) begin
					$error("prescaler mismatch: expected %0d, actual %0d",
						exp_s.prescaler, prescaler);
					error_count++;
				end
				if (reload !== exp_s.reload) begin
					$error("reload mismatch: expected %0d, actual %0d",
						exp_s.reload, reload);
					error_count++;
				end
				if (out_of_range !== exp_s.out_of_range) begin
					$error("out_of_range mismatch: expected %0d, actual %0d",
						exp_s.out_of_range, out_of_range);
					error_count++;
				end
			end
		end
		if (stall_phase_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_phase_left = $urandom_range(50, 400);
		end else begin
			stall_phase_left--;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: begin
				if (stall_run_left == 0) begin
					stall_level = ~stall_level;
					stall_run_left = $urandom_range(1, 12);
				end else begin
					stall_run_left--;
				end
				out_stall <= stall_level;
			end
		endcase
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_field_extremes();
		test_prescaler_steps();
		test_range_edge();
		test_random_delays();
		in_valid <= 1'b0;
		while (pending_settings.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d timeout requests (%0d past the prescaler range), %0d results checked,",
			requests_sent, overrange_sent, results_checked);
		$display("with bursty input and random output stalls; %0d mismatches.", error_count);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
